/* sv/lpr_pkg.sv */
// Package for the LRU page replacement block: request and result types,
// controller command and status structs, field widths and command codes.
// No dependencies.
package lpr_pkg;

  localparam int PAGE_BITS  = 16;
  localparam int FIDX_BITS  = 3;
  localparam int COUNT_BITS = 32;
  localparam int CFG_BITS   = 4;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [PAGE_BITS-1:0] page;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [FIDX_BITS-1:0]  frame_index;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] fault_total;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic issue;
    logic eval;
    logic update;
  } lpr_cmd_t;

  typedef struct packed {
    logic issue_last;
  } lpr_stat_t;

endpackage

/* sv/lpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/lpr_datapath.sv */
// Datapath for the LRU page replacement block: frame tables, valid bits,
// access time, fault count, scan trackers and the result register.
// Depends on lpr_pkg and lpr_ram.
module lpr_datapath #(
  parameter int NUM_FRAMES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpr_pkg::lpr_cmd_t                cmd,
  output lpr_pkg::lpr_stat_t               stat,
  input  lpr_pkg::req_t                    req,
  input  logic                             cfg_we,
  input  logic [lpr_pkg::CFG_BITS-1:0]     cfg_wdata,
  output lpr_pkg::rsp_t                    rsp
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int PB = lpr_pkg::PAGE_BITS;
  localparam int CB = lpr_pkg::COUNT_BITS;

  logic [lpr_pkg::CFG_BITS-1:0] cfg_r;
  logic [PB-1:0]                page_r;
  logic [CB-1:0]                time_r;
  logic [CB-1:0]                fault_r;
  logic [NUM_FRAMES-1:0]        valid_r;
  logic [IW-1:0]                rd_idx_r;
  logic [IW-1:0]                ev_idx_r;
  logic                         ev_live_r;
  logic                         hit_r;
  logic                         empty_r;
  logic [IW-1:0]                hit_idx_r;
  logic [IW-1:0]                empty_idx_r;
  logic [IW-1:0]                min_idx_r;
  logic [CB-1:0]                min_time_r;
  logic [PB-1:0]                min_page_r;
  lpr_pkg::rsp_t                rsp_r;

  logic [6:0]    cfg_ext;
  logic [6:0]    n_act;
  logic [IW-1:0] last_idx;
  logic [PB-1:0] pg_rd;
  logic [CB-1:0] lu_rd;
  logic          eval_go;
  logic          ev_valid;
  logic          ev_match;
  logic [IW-1:0] victim;
  logic [CB-1:0] fault_inc;
  logic          pg_we;
  logic          lu_we;
  logic [IW-1:0] lu_waddr;

  always_comb begin
    cfg_ext = {3'b000, cfg_r};
    if (cfg_ext == 7'd0) begin
      n_act = 7'd1;
    end else if (cfg_ext > 7'(NUM_FRAMES)) begin
      n_act = 7'(NUM_FRAMES);
    end else begin
      n_act = cfg_ext;
    end
    last_idx  = IW'(n_act - 7'd1);
    eval_go   = cmd.eval && ev_live_r;
    ev_valid  = valid_r[ev_idx_r];
    ev_match  = eval_go && ev_valid && (pg_rd == page_r);
    victim    = empty_r ? empty_idx_r : min_idx_r;
    fault_inc = (fault_r == '1) ? fault_r : fault_r + CB'(1);
    pg_we     = cmd.update && !hit_r;
    lu_we     = ev_match || pg_we;
    lu_waddr  = ev_match ? ev_idx_r : victim;
  end

  assign stat.issue_last = (rd_idx_r == last_idx);

  lpr_ram #(.WIDTH(PB), .DEPTH(NUM_FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (victim),
    .wdata (page_r),
    .raddr (rd_idx_r),
    .rdata (pg_rd)
  );

  lpr_ram #(.WIDTH(CB), .DEPTH(NUM_FRAMES)) u_use_ram (
    .clk   (clk),
    .we    (lu_we),
    .waddr (lu_waddr),
    .wdata (time_r),
    .raddr (rd_idx_r),
    .rdata (lu_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= lpr_pkg::CFG_RESET;
      time_r    <= '0;
      fault_r   <= '0;
      valid_r   <= '0;
      ev_live_r <= 1'b0;
    end else begin
      ev_live_r <= cmd.issue;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        time_r  <= '0;
        fault_r <= '0;
        valid_r <= '0;
      end
      if (cmd.load && (time_r != '1)) begin
        time_r <= time_r + CB'(1);
      end
      if (pg_we) begin
        valid_r[victim] <= 1'b1;
        fault_r         <= fault_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r   <= req.page;
      rd_idx_r <= '0;
      hit_r    <= 1'b0;
      empty_r  <= 1'b0;
    end
    if (cmd.issue) begin
      rd_idx_r <= rd_idx_r + IW'(1);
      ev_idx_r <= rd_idx_r;
    end
    if (ev_match && !hit_r) begin
      hit_r     <= 1'b1;
      hit_idx_r <= ev_idx_r;
    end
    if (eval_go && !ev_valid && !empty_r) begin
      empty_r     <= 1'b1;
      empty_idx_r <= ev_idx_r;
    end
    if (eval_go && ((ev_idx_r == '0) || (lu_rd < min_time_r))) begin
      min_time_r <= lu_rd;
      min_idx_r  <= ev_idx_r;
      min_page_r <= pg_rd;
    end
    if (cmd.clear) begin
      rsp_r <= '0;
    end
    if (cmd.update) begin
      rsp_r.hit           <= hit_r;
      rsp_r.frame_index   <= hit_r ? lpr_pkg::FIDX_BITS'(hit_idx_r)
                                   : lpr_pkg::FIDX_BITS'(victim);
      rsp_r.evicted_valid <= !hit_r && !empty_r;
      rsp_r.evicted_page  <= (!hit_r && !empty_r) ? min_page_r : '0;
      rsp_r.fault_total   <= hit_r ? fault_r : fault_inc;
    end
  end

  assign rsp = rsp_r;

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> !(rsp_r.hit && rsp_r.evicted_valid))
    else $error("hit reported together with an eviction");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clear |=> fault_r >= $past(fault_r))
    else $error("fault count went down without a clear");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (fault_r == '0) && (valid_r == '0))
    else $error("clear left frames or faults behind");

endmodule

/* sv/lpr_ctrl.sv */
// Controller for the LRU page replacement block: sequences the frame scan,
// the update and the result strobe.
// Depends on lpr_pkg.
module lpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               is_clear,
  input  lpr_pkg::lpr_stat_t stat,
  output lpr_pkg::lpr_cmd_t  cmd,
  output logic               busy,
  output logic               out_strobe
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   strobe_r;
  logic   strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (is_clear) begin
            cmd.clear  = 1'b1;
            strobe_nxt = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        cmd.eval  = 1'b1;
        if (stat.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.eval  = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r == S_UPDATE || (state_r == S_IDLE && start && is_clear)))
    else $error("result strobe without update or clear");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == S_IDLE)
    else $error("result strobe while busy");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> $past(state_r) == S_SCAN)
    else $error("drain not preceded by scan");

endmodule

/* sv/lru_page_replacement.sv */
// LRU page replacement, top level. A page reference is a scan of the n
// active frames, n being the active frame count (the frame-count setting
// clamped to 1..NUM_FRAMES), then a drain and an update state; the result
// strobe is registered from the update state. One read port on the frame
// RAMs is swept one frame per cycle for match, empty and oldest in a single
// pass. A clear needs no scan. Results are shown for one cycle, cannot stall.
// Depends on lpr_pkg, lpr_ctrl, lpr_datapath and lpr_ram.
module lru_page_replacement #(
  parameter int NUM_FRAMES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  lpr_pkg::req_t                in_req,
  output logic                         out_strobe,
  output lpr_pkg::rsp_t                out_rsp,
  input  logic                         cfg_we,
  input  logic [lpr_pkg::CFG_BITS-1:0] cfg_wdata
);

  lpr_pkg::lpr_cmd_t  cmd;
  lpr_pkg::lpr_stat_t stat;

  lpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .is_clear   (in_req.command == lpr_pkg::CMD_CLEAR),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  lpr_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .req       (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rsp       (out_rsp)
  );

endmodule

/* tb/sv/lru_page_replacement_test.sv */
// Self-checking testbench for lru_page_replacement: a table of directed
// requests, then random phases over frame-count settings, checked against a
// timestamp LRU predictor. Depends on lpr_pkg and lru_page_replacement.
module lru_page_replacement_test;
  import lpr_pkg::*;

  localparam int NFR       = 8;
  localparam int RND_ITEMS = 750;
  localparam int LIMIT     = 200000;

  typedef enum logic [1:0] {ROW_REF, ROW_CLEAR, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [PAGE_BITS-1:0] arg;
    bit                   typed;
    rsp_t                 exp;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  req_t                in_req = '0;
  logic                out_strobe;
  rsp_t                out_rsp;
  logic                cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  bit   tag_typed = 1'b0;
  rsp_t tag_exp = '0;

  logic [CFG_BITS-1:0]   cfg_frames = CFG_RESET;
  logic [PAGE_BITS-1:0]  fr_page [NFR];
  bit                    fr_valid [NFR];
  logic [COUNT_BITS-1:0] fr_stamp [NFR];
  logic [COUNT_BITS-1:0] tick;
  logic [COUNT_BITS-1:0] faults;

  rsp_t pending_rsp [$];
  step_row_t dir_tab [$];
  logic [PAGE_BITS-1:0] page_pool [$];
  logic [CFG_BITS-1:0] extreme_cfg [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

  int mismatches = 0;
  int cycle_count = 0;
  int n_req = 0;
  int n_hit = 0;
  int n_fault = 0;
  int n_evict = 0;
  int n_clear = 0;
  int n_cfg = 0;

  lru_page_replacement #(.NUM_FRAMES(NFR)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_frames();
    for (int k = 0; k < NFR; k++) begin
      fr_page[k]  = '0;
      fr_valid[k] = 1'b0;
      fr_stamp[k] = '0;
    end
    tick   = '0;
    faults = '0;
  endfunction

  function automatic rsp_t lru_predict(req_t r);
    rsp_t o;
    int   n;
    bit   found;
    o = '0;
    if (r.command == CMD_CLEAR) begin
      clear_frames();
      return o;
    end
    n = (cfg_frames == 0) ? 1 : ((cfg_frames > NFR) ? NFR : int'(cfg_frames));
    if (tick != '1) tick++;
    for (int k = 0; k < n; k++) begin
      if (fr_valid[k] && fr_page[k] == r.page) begin
        if (!o.hit) o.frame_index = 3'(k);
        o.hit = 1'b1;
        fr_stamp[k] = tick;
      end
    end
    if (!o.hit) begin
      found = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (!found && !fr_valid[k]) begin
          o.frame_index = 3'(k);
          found = 1'b1;
        end
      end
      if (!found) begin
        o.frame_index = '0;
        for (int k = 1; k < n; k++) begin
          if (fr_stamp[k] < fr_stamp[o.frame_index]) o.frame_index = 3'(k);
        end
        o.evicted_valid = 1'b1;
        o.evicted_page  = fr_page[o.frame_index];
      end
      fr_page[o.frame_index]  = r.page;
      fr_valid[o.frame_index] = 1'b1;
      fr_stamp[o.frame_index] = tick;
      if (faults != '1) faults++;
    end
    o.fault_total = faults;
    return o;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_monitor
    rsp_t pred;
    rsp_t want;
    if (rst_n) begin
      if (cfg_we) cfg_frames = cfg_wdata;
      if (start && !busy) begin
        pred = lru_predict(in_req);
        pending_rsp.push_back(tag_typed ? tag_exp : pred);
        if (in_req.command == CMD_CLEAR) n_clear++;
        else begin
          n_req++;
          if (pred.hit) n_hit++;
          else n_fault++;
          if (pred.evicted_valid) n_evict++;
        end
      end
      if (out_strobe) begin
        if (pending_rsp.size() == 0) begin
          flag_error("result with no request outstanding");
        end else begin
          want = pending_rsp.pop_front();
          check_field("hit", out_rsp.hit, want.hit);
          check_field("frame_index", out_rsp.frame_index, want.frame_index);
          check_field("evicted_valid", out_rsp.evicted_valid, want.evicted_valid);
          check_field("evicted_page", out_rsp.evicted_page, want.evicted_page);
          check_field("fault_total", out_rsp.fault_total, want.fault_total);
        end
      end
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(req_t r, bit typed, rsp_t e, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req    <= r;
    tag_typed <= typed;
    tag_exp   <= e;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_until_empty();
    start <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_BITS-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[lru_page_replacement] ERROR");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    bit   quiet;
    int   rnd_items;
    int   phase;
    int   len;
    int   pick;
    clear_frames();
    dir_tab = '{
      '{ROW_REF,   16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
      '{ROW_REF,   16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
      '{ROW_REF,   16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
      '{ROW_REF,   16'h5555, 1'b0, '0},
      '{ROW_REF,   16'hAAAA, 1'b0, '0},
      '{ROW_REF,   16'h0001, 1'b0, '0},
      '{ROW_REF,   16'h8000, 1'b0, '0},
      '{ROW_REF,   16'h1234, 1'b0, '0},
      '{ROW_REF,   16'h4321, 1'b0, '0},
      '{ROW_REF,   16'h7FFF, 1'b1, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd9}},
      '{ROW_CLEAR, 16'hFFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd0}},
      '{ROW_REF,   16'hFFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
      '{ROW_CFG,   16'd1,    1'b0, '0},
      '{ROW_REF,   16'h0002, 1'b0, '0},
      '{ROW_REF,   16'h0002, 1'b0, '0},
      '{ROW_CFG,   16'd0,    1'b0, '0},
      '{ROW_REF,   16'h0003, 1'b0, '0},
      '{ROW_CFG,   16'd15,   1'b0, '0},
      '{ROW_REF,   16'h0003, 1'b0, '0},
      '{ROW_CLEAR, 16'h0000, 1'b0, '0},
      '{ROW_REF,   16'h0010, 1'b0, '0},
      '{ROW_REF,   16'h0020, 1'b0, '0},
      '{ROW_REF,   16'h0030, 1'b0, '0},
      '{ROW_CFG,   16'd2,    1'b0, '0},
      '{ROW_REF,   16'h0030, 1'b0, '0},
      '{ROW_CFG,   16'd9,    1'b0, '0},
      '{ROW_REF,   16'h0030, 1'b0, '0},
      '{ROW_REF,   16'h0040, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        idle_until_empty();
        write_cfg(dir_tab[i].arg[CFG_BITS-1:0]);
      end else begin
        r.command = (dir_tab[i].kind == ROW_CLEAR) ? CMD_CLEAR : CMD_REF;
        r.page    = dir_tab[i].arg;
        send(r, dir_tab[i].typed, dir_tab[i].exp, pick_gap(1'b0));
      end
    end

    rnd_items = 0;
    phase     = 0;
    while (rnd_items < RND_ITEMS) begin
      idle_until_empty();
      write_cfg((phase < 4) ? extreme_cfg[phase] : CFG_BITS'($urandom_range(0, 15)));
      // keep the pool across some phases so resizing leaves duplicates behind
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        page_pool.delete();
        repeat ($urandom_range(1, 12)) begin
          pick = $urandom_range(0, 9);
          page_pool.push_back((pick == 0) ? 16'h0000 :
                              (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535)));
        end
      end
      quiet = ($urandom_range(0, 3) == 0);
      len   = $urandom_range(40, 90);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        r.command = (pick < 2) ? CMD_CLEAR : CMD_REF;
        r.page    = (pick < 2 || pick >= 85) ? 16'($urandom_range(0, 65535)) :
                    page_pool[$urandom_range(0, page_pool.size() - 1)];
        send(r, 1'b0, '0, pick_gap(quiet));
        rnd_items++;
        if ($urandom_range(0, 60) == 0) idle_until_empty();
      end
      phase++;
    end

    idle_until_empty();
    repeat (16) @(posedge clk);
    if (pending_rsp.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_rsp.size()));
    $display("covered %0d page requests: %0d hits, %0d faults, %0d evictions, %0d clears",
             n_req, n_hit, n_fault, n_evict, n_clear);
    $display("%0d frame-count writes over %0d cycles, %0d mismatches",
             n_cfg, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("[lru_page_replacement] OK");
    end else begin
      $display("[lru_page_replacement] ERROR");
    end
    $finish;
  end

endmodule
